>>> src/sup_pkg.sv
// Shared types and constants for the scanline pixel unpacker.
package sup_pkg;

  // Transaction opcodes on the byte channel
  typedef enum logic [1:0] {
    OP_DATA      = 2'd0,
    OP_PAL_RGB   = 2'd1,
    OP_PAL_ALPHA = 2'd2
  } op_t;

  // Pixel formats; the unused code behaves as palette mode
  typedef enum logic [1:0] {
    FMT_PALETTE = 2'd0,
    FMT_RGB     = 2'd1,
    FMT_RGBA    = 2'd2
  } fmt_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam int unsigned DIM_W   = 13;  // width/height register bits
  localparam int unsigned CMP_W   = 18;  // covers any dimension bound plus one
  localparam int unsigned CFG_D_W = 13;  // widest register

  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [1:0]       fmt;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // Palette write command
  typedef struct packed {
    logic        we_rgb;
    logic        we_alpha;
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic [7:0]  alpha;
  } pal_wr_t;

  // Per-transaction outcome of the assembler
  typedef struct packed {
    logic        done;     // a pixel completes with this byte
    logic        use_pal;  // pixel comes from the palette
    logic [31:0] argb;     // assembled pixel for RGB/RGBA
    logic        last;     // final pixel of the image
  } asm_res_t;

endpackage

>>> src/sup_in_if.sv
// Byte channel: opcode, stream byte and palette write fields.
interface sup_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic [7:0]  pal_index;
  logic [23:0] pal_rgb;

  modport source (output valid, op, data_byte, pal_index, pal_rgb, input ready);
  modport sink   (input valid, op, data_byte, pal_index, pal_rgb, output ready);
endinterface

>>> src/sup_out_if.sv
// Pixel channel: ARGB pixel and last-pixel flag.
interface sup_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic        last_pixel;

  modport source (output valid, pixel_argb, last_pixel, input ready);
  modport sink   (input valid, pixel_argb, last_pixel, output ready);
endinterface

>>> src/sup_palette.sv
// Palette memory: separate color and alpha arrays, one valid bit per entry, registered read.
module sup_palette
  import sup_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  pal_wr_t     wr,
  input  logic        rd_en,
  input  logic [7:0]  rd_idx,
  output logic [31:0] rd_argb
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic [23:0] rgb_mem   [PALETTE_ENTRIES];
  logic [7:0]  alpha_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_vld;

  logic        wr_ok;
  logic        rd_ok;
  logic [AW-1:0] wr_a;
  logic [AW-1:0] rd_a;

  // per-memory write port
  logic        wr_fresh;
  logic        rgb_we;
  logic [23:0] rgb_wd;
  logic        alpha_we;
  logic [7:0]  alpha_wd;

  // read-side registers
  logic [23:0] rd_rgb;
  logic [7:0]  rd_alpha;
  logic        rd_vld;
  logic        rd_in_range;

  assign wr_ok = 9'(wr.idx) < 9'(PALETTE_ENTRIES);
  assign rd_ok = 9'(rd_idx) < 9'(PALETTE_ENTRIES);
  assign wr_a  = wr.idx[AW-1:0];
  assign rd_a  = rd_idx[AW-1:0];

  // first write to an entry also fills the other half with opaque black
  assign wr_fresh = !pal_vld[wr_a];
  assign rgb_we   = wr_ok && (wr.we_rgb || (wr.we_alpha && wr_fresh));
  assign rgb_wd   = wr.we_rgb ? wr.rgb : 24'h0;
  assign alpha_we = wr_ok && (wr.we_alpha || (wr.we_rgb && wr_fresh));
  assign alpha_wd = wr.we_alpha ? wr.alpha : ALPHA_OPAQUE;

  // memory writes
  always_ff @(posedge clk) begin
    if (rgb_we) begin
      rgb_mem[wr_a] <= rgb_wd;
    end
    if (alpha_we) begin
      alpha_mem[wr_a] <= alpha_wd;
    end
  end

  // valid bits: an entry never written reads as opaque black
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if ((wr.we_rgb || wr.we_alpha) && wr_ok) begin
      pal_vld[wr_a] <= 1'b1;
    end
  end

  // registered read, held while the output stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rgb      <= rgb_mem[rd_a];
      rd_alpha    <= alpha_mem[rd_a];
      rd_vld      <= pal_vld[rd_a];
      rd_in_range <= rd_ok;
    end
  end

  always_comb begin
    if (!rd_in_range || !rd_vld) begin
      rd_argb = OPAQUE_BLACK;
    end else begin
      rd_argb = {rd_alpha, rd_rgb};
    end
  end

endmodule

>>> src/sup_assemble.sv
// Byte assembler and row/column position tracking.
module sup_assemble
  import sup_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output asm_res_t   res
);

  localparam int unsigned COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic             at_row_start, at_row_start_next;
  logic [1:0]       byte_phase, byte_phase_next;
  logic [23:0]      assembly, assembly_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  logic             is_data;
  logic             is_rgb, is_rgba;
  logic [2:0]       need;
  logic [CMP_W-1:0] w_eff, h_eff;
  logic             row_end, img_end;

  assign is_data = (op == OP_DATA);
  assign is_rgb  = (cfg.fmt == FMT_RGB);
  assign is_rgba = (cfg.fmt == FMT_RGBA);
  assign need    = is_rgb ? 3'd3 : (is_rgba ? 3'd4 : 3'd1);

  // clamp dimensions to [1, MAX]
  always_comb begin
    if (cfg.width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(cfg.width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(cfg.height) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = CMP_W'(cfg.height);
    end
  end

  assign row_end = (CMP_W'(column_count) + CMP_W'(1)) >= w_eff;
  assign img_end = (CMP_W'(row_count) + CMP_W'(1)) >= h_eff;

  // next state and result
  always_comb begin
    at_row_start_next = at_row_start;
    byte_phase_next   = byte_phase;
    assembly_next     = assembly;
    column_count_next = column_count;
    row_count_next    = row_count;
    res.done    = 1'b0;
    res.use_pal = !is_rgb && !is_rgba;
    res.last    = 1'b0;
    res.argb    = is_rgb ? {ALPHA_OPAQUE, assembly[15:0], data_byte}
                         : {data_byte, assembly};

    if (is_data) begin
      if (at_row_start) begin
        // filter-type byte, dropped
        at_row_start_next = 1'b0;
        byte_phase_next   = 2'd0;
        assembly_next     = '0;
      end else if ((3'(byte_phase) + 3'd1) < need) begin
        assembly_next   = {assembly[15:0], data_byte};
        byte_phase_next = byte_phase + 2'd1;
      end else begin
        res.done        = 1'b1;
        byte_phase_next = 2'd0;
        assembly_next   = '0;
        if (row_end) begin
          column_count_next = '0;
          at_row_start_next = 1'b1;
          if (img_end) begin
            row_count_next = '0;
            res.last       = 1'b1;
          end else begin
            row_count_next = row_count + ROW_W'(1);
          end
        end else begin
          column_count_next = column_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_row_start <= 1'b1;
      byte_phase   <= 2'd0;
      assembly     <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      at_row_start <= at_row_start_next;
      byte_phase   <= byte_phase_next;
      assembly     <= assembly_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

>>> src/scanline_pixel_unpacker.sv
// Top level: configuration registers, palette, assembler and output register.
//
//  channel   dir  handshake       payload
//  byte_in   in   valid/ready     op, data_byte, pal_index, pal_rgb
//  pix_out   out  valid/ready     pixel_argb, last_pixel
//  cfg       in   cfg_we          cfg_index, cfg_data
//
// One byte transaction is accepted per cycle while byte_in.ready is high; a completed
// pixel appears on pix_out in the cycle after the byte that completes it, from the output
// register that also holds the registered palette read.
// byte_in.ready is high whenever the output register is empty or being drained.
// Reset (rst, synchronous) clears the position state and the palette valid bits;
// no clearing pass is needed.
module scanline_pixel_unpacker
  import sup_pkg::*;
#(
  parameter int unsigned MAX_WIDTH       = 4096,
  parameter int unsigned MAX_HEIGHT      = 4096,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  sup_in_if.sink             byte_in,
  sup_out_if.source          pix_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data
);

  cfg_t     cfg;
  pal_wr_t  pal_wr;
  asm_res_t res;
  logic     accept;
  logic     pal_rd_en;
  logic [31:0] pal_argb;

  // output register
  logic        out_valid;
  logic        out_use_pal;
  logic [31:0] out_argb;
  logic        out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt    <= FMT_PALETTE;
      cfg.width  <= DIM_W'(1);
      cfg.height <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: cfg.fmt    <= cfg_data[1:0];
        CFG_WIDTH:  cfg.width  <= cfg_data;
        CFG_HEIGHT: cfg.height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign byte_in.ready = !out_valid || pix_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  // palette write command
  assign pal_wr.we_rgb   = accept && (byte_in.op == OP_PAL_RGB);
  assign pal_wr.we_alpha = accept && (byte_in.op == OP_PAL_ALPHA);
  assign pal_wr.idx      = byte_in.pal_index;
  assign pal_wr.rgb      = byte_in.pal_rgb;
  assign pal_wr.alpha    = byte_in.data_byte;

  assign pal_rd_en = accept && res.done && res.use_pal;

  sup_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .rst    (rst),
    .wr     (pal_wr),
    .rd_en  (pal_rd_en),
    .rd_idx (byte_in.data_byte),
    .rd_argb(pal_argb)
  );

  sup_assemble #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_assemble (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .op       (byte_in.op),
    .data_byte(byte_in.data_byte),
    .cfg      (cfg),
    .res      (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.done;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept && res.done) begin
      out_use_pal <= res.use_pal;
      out_argb    <= res.argb;
      out_last    <= res.last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_argb = out_use_pal ? pal_argb : out_argb;
  assign pix_out.last_pixel = out_last;

  // a pixel completed by an accepted byte shows up next cycle with its flag
  a_done_to_out: assert property (@(posedge clk) disable iff (rst)
    (accept && res.done) |=> (pix_out.valid && pix_out.last_pixel == $past(res.last)))
    else $error("completed pixel missing from output register");

  // palette writes never produce a pixel
  a_pal_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (accept && (byte_in.op == OP_PAL_RGB || byte_in.op == OP_PAL_ALPHA)) |-> !res.done)
    else $error("palette write completed a pixel");

  // a stalled pixel keeps its value, palette read data included
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.ready) |=> $stable(pix_out.pixel_argb))
    else $error("stalled pixel changed");

endmodule

>>> sim/scanline_pixel_unpacker_tb.sv
`timescale 1ns / 1ps
// Scoreboard testbench for the scanline pixel unpacker: directed and random byte streams.
import sup_pkg::*;

// One transaction on the byte channel
typedef struct packed {
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic [7:0]  pal_index;
  logic [23:0] pal_rgb;
} byte_txn_t;

// Predicts pixels from accepted bytes and checks the pixel channel against them
class pixel_scoreboard;
  typedef struct packed {
    logic [31:0] argb;
    logic        last;
  } pixel_t;

  localparam int unsigned MAX_DIM = 4096;

  logic [31:0] palette [256];
  logic [1:0]  fmt;
  logic [12:0] width;
  logic [12:0] height;
  logic [11:0] col;
  logic [11:0] row;
  logic        row_start;
  logic [1:0]  phase;
  logic [23:0] acc;
  pixel_t      pixel_q[$];
  int unsigned mismatches;

  function new();
    foreach (palette[i]) palette[i] = OPAQUE_BLACK;
    fmt        = FMT_PALETTE;
    width      = 13'd1;
    height     = 13'd1;
    col        = '0;
    row        = '0;
    row_start  = 1'b1;
    phase      = '0;
    acc        = '0;
    mismatches = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [12:0] val);
    case (idx)
      CFG_FORMAT: fmt = val[1:0];
      CFG_WIDTH:  width = val;
      CFG_HEIGHT: height = val;
      default: ;
    endcase
  endfunction

  // Zero reads as one, anything past the maximum as the maximum
  function logic [13:0] bound(logic [12:0] v);
    if (v == 13'd0) return 14'd1;
    if (v > MAX_DIM) return 14'(MAX_DIM);
    return {1'b0, v};
  endfunction

  function int unsigned outstanding();
    return pixel_q.size();
  endfunction

  function void note_byte(byte_txn_t t);
    logic [2:0]  need;
    logic [31:0] px;
    logic        last;
    case (t.op)
      OP_PAL_RGB: palette[t.pal_index] = {palette[t.pal_index][31:24], t.pal_rgb};
      OP_PAL_ALPHA: palette[t.pal_index] = {t.data_byte, palette[t.pal_index][23:0]};
      OP_DATA: begin
        // filter-type byte opens each row and is dropped
        if (row_start) begin
          row_start = 1'b0;
          phase     = '0;
          acc       = '0;
          return;
        end
        case (fmt)
          FMT_RGB:  need = 3'd3;
          FMT_RGBA: need = 3'd4;
          default:  need = 3'd1;
        endcase
        if ({1'b0, phase} + 3'd1 < need) begin
          acc   = {acc[15:0], t.data_byte};
          phase = phase + 2'd1;
          return;
        end
        case (need)
          3'd3:    px = {8'hFF, acc[15:0], t.data_byte};
          3'd4:    px = {t.data_byte, acc};
          default: px = palette[t.data_byte];
        endcase
        phase = '0;
        acc   = '0;
        // advance position; counters past a shrunk bound end the row at once
        last = 1'b0;
        if ({2'b0, col} + 14'd1 >= bound(width)) begin
          col       = '0;
          row_start = 1'b1;
          if ({2'b0, row} + 14'd1 >= bound(height)) begin
            row  = '0;
            last = 1'b1;
          end else begin
            row = row + 12'd1;
          end
        end else begin
          col = col + 12'd1;
        end
        pixel_q.push_back('{argb: px, last: last});
      end
      default: ;
    endcase
  endfunction

  function void check_pixel(logic [31:0] argb, logic last);
    pixel_t exp_px;
    if (pixel_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: pixel %h last %b arrived with nothing expected", argb, last);
      return;
    end
    exp_px = pixel_q.pop_front();
    if (argb !== exp_px.argb || last !== exp_px.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected pixel %h last %b, got pixel %h last %b",
                 exp_px.argb, exp_px.last, argb, last);
    end
  endfunction
endclass

module scanline_pixel_unpacker_tb;
  localparam int unsigned RANDOM_ITEMS  = 1400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [1:0]  FMT_UNUSED    = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [CFG_D_W-1:0] cfg_data;

  sup_in_if  byte_in ();
  sup_out_if pix_out ();

  pixel_scoreboard sb;
  byte_txn_t       stim_q[$];
  int unsigned     stall_pct;
  int unsigned     hold_left;
  bit              no_gaps;

  scanline_pixel_unpacker u_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .pix_out  (pix_out),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Pixel receiver: checks each accepted transaction, stalls in random runs
  initial begin
    int unsigned run_left;
    logic        run_level;
    run_left      = 0;
    run_level     = 1'b1;
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pix_out.valid && pix_out.ready)
        sb.check_pixel(pix_out.pixel_argb, pix_out.last_pixel);
      if (hold_left > 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_level = ($urandom_range(0, 99) >= stall_pct);
          run_left  = $urandom_range(1, 6);
        end
        run_left--;
        pix_out.ready <= run_level;
      end
    end
  end

  function automatic byte_txn_t txn(logic [1:0] op, logic [7:0] b, logic [7:0] idx,
                                    logic [23:0] rgb);
    byte_txn_t t;
    t.op        = op;
    t.data_byte = b;
    t.pal_index = idx;
    t.pal_rgb   = rgb;
    return t;
  endfunction

  function automatic byte_txn_t rand_txn();
    byte_txn_t   t;
    int unsigned pick;
    t.data_byte = $urandom;
    t.pal_index = $urandom;
    t.pal_rgb   = $urandom;
    // half the time stay on a few entries so written colors get read back
    if ($urandom_range(0, 1) == 1) begin
      t.data_byte = $urandom_range(0, 7);
      t.pal_index = $urandom_range(0, 7);
    end
    pick = $urandom_range(0, 99);
    if (pick < 78)      t.op = OP_DATA;
    else if (pick < 87) t.op = OP_PAL_RGB;
    else if (pick < 95) t.op = OP_PAL_ALPHA;
    else                t.op = OP_UNUSED;
    return t;
  endfunction

  function automatic logic [12:0] rand_dim(int unsigned small_max);
    case ($urandom_range(0, 9))
      7:       return 13'd0;
      8:       return ($urandom_range(0, 1) == 1) ? 13'd4096 : 13'h1FFF;
      9:       return 13'($urandom);
      default: return 13'($urandom_range(1, small_max));
    endcase
  endfunction

  // Offer one transaction and wait for it to be taken
  task automatic drive_txn(byte_txn_t t);
    byte_in.valid     <= 1'b1;
    byte_in.op        <= t.op;
    byte_in.data_byte <= t.data_byte;
    byte_in.pal_index <= t.pal_index;
    byte_in.pal_rgb   <= t.pal_rgb;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
    sb.note_byte(t);
  endtask

  task automatic idle_sender(int unsigned n);
    byte_in.valid     <= 1'b0;
    byte_in.op        <= 2'($urandom);
    byte_in.data_byte <= 8'($urandom);
    byte_in.pal_index <= 8'($urandom);
    byte_in.pal_rgb   <= 24'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Send the queued stimulus in bursts with random gaps, or back to back when no_gaps is set
  task automatic send_stim();
    int unsigned burst;
    burst = $urandom_range(1, 16);
    while (stim_q.size() > 0) begin
      if (!no_gaps && burst == 0) begin
        idle_sender($urandom_range(1, 8));
        burst = $urandom_range(1, 24);
      end
      drive_txn(stim_q.pop_front());
      if (burst > 0) burst--;
    end
    idle_sender(1);
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Write the registers selected by mask (bit 0 format, 1 width, 2 height)
  task automatic set_config(logic [2:0] mask, logic [1:0] fmt, logic [12:0] w,
                            logic [12:0] h);
    if (mask[0]) write_reg(CFG_FORMAT, 13'(fmt));
    if (mask[1]) write_reg(CFG_WIDTH, w);
    if (mask[2]) write_reg(CFG_HEIGHT, h);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase_idx;
    sb                = new();
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_FORMAT;
    cfg_data          = '0;
    byte_in.valid     = 1'b0;
    byte_in.op        = OP_DATA;
    byte_in.data_byte = '0;
    byte_in.pal_index = '0;
    byte_in.pal_rgb   = '0;
    stall_pct         = 0;
    hold_left         = 0;
    no_gaps           = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset palette, palette writes at the extremes, unused opcode, 1x1 images
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_PAL_RGB, 8'h00, 8'hFF, 24'hFFFFFF));
    stim_q.push_back(txn(OP_PAL_ALPHA, 8'h00, 8'hFF, 24'h000000));
    stim_q.push_back(txn(OP_PAL_ALPHA, 8'hFF, 8'h00, 24'hFFFFFF));
    stim_q.push_back(txn(OP_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF));
    stim_q.push_back(txn(OP_DATA, 8'hFF, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'hFF, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    send_stim();
    drain();

    // RGB row of two, palette write in the middle of a pixel
    set_config(3'b111, FMT_RGB, 13'd2, 13'd1);
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'hFF, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_PAL_RGB, 8'h00, 8'h01, 24'h123456));
    stim_q.push_back(txn(OP_DATA, 8'hFF, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    send_stim();
    drain();

    // RGBA with zero width and height above the maximum
    set_config(3'b111, FMT_RGBA, 13'd0, 13'h1FFF);
    stim_q.push_back(txn(OP_DATA, 8'hFF, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h12, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h34, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h56, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    send_stim();
    drain();

    // Unused format code reads the palette
    set_config(3'b001, FMT_UNUSED, 13'd0, 13'd0);
    stim_q.push_back(txn(OP_DATA, 8'h00, 8'h00, 24'h000000));
    stim_q.push_back(txn(OP_DATA, 8'hFF, 8'h00, 24'h000000));
    send_stim();
    drain();

    // Random phases; position counters carry over between them
    sent      = 0;
    phase_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase_idx)
        0:       set_config(3'b111, FMT_RGB, 13'd4096, 13'd4096);
        1:       set_config(3'b111, FMT_PALETTE, 13'd1, 13'd1);
        2:       set_config(3'b111, FMT_PALETTE, 13'd3, 13'd2);
        default: set_config(3'($urandom_range(1, 7)), 2'($urandom_range(0, 3)),
                            rand_dim(6), rand_dim(4));
      endcase
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      n = (phase_idx == 2) ? 120 : $urandom_range(40, 120);
      repeat (n) stim_q.push_back(rand_txn());
      // long receiver hold-off while the sender keeps pushing
      if (phase_idx == 2) begin
        no_gaps   = 1'b1;
        stall_pct = 0;
        hold_left = 400;
      end
      send_stim();
      sent += n;
      drain();
      phase_idx++;
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
